// File: hdl/assert_macros.svh
// Assertion macros used by the checker in hll_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent implication checked on the rising clock edge, off during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/hll_pkg.sv
package hll_pkg;

    localparam int DefBuckets = 2048;
    localparam int FracBits = 22;
    localparam int RankW = 5;
    localparam int EstW = 33;
    localparam logic [31:0] HashMul = 32'h045d9f3b;
    localparam logic [EstW-1:0] EstMax = {EstW{1'b1}};

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b00000001,
        ST_IDLE  = 8'b00000010,
        ST_HASH  = 8'b00000100,
        ST_ADD   = 8'b00001000,
        ST_SCAN  = 8'b00010000,
        ST_LAST  = 8'b00100000,
        ST_DIV   = 8'b01000000,
        ST_OUT   = 8'b10000000
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic clear_wr;   // write zero at the scan address
        logic hash_load;  // capture the incoming value
        logic hash_rd;    // finish the hash and read the hashed bucket
        logic add_wr;     // read-modify-write of the hashed bucket
        logic scan_rd;    // read at the scan address
        logic scan_acc;   // accumulate the bucket read last cycle
        logic addr_inc;   // step the scan address
        logic sum_clr;
        logic div_start;
        logic div_step;
        logic out_fire;
    } ctrl_t;

    // Datapath to controller.
    typedef struct packed {
        logic addr_last;
        logic div_done;
    } stat_t;

    function automatic int clog2_floor(input int m);
        int b;
        b = 0;
        while ((m >> (b + 1)) != 0) b++;
        return b;
    endfunction

endpackage

// File: hdl/hll_ram.sv
module hll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: hdl/hll_ctrl.sv
module hll_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           mode,
    input  hll_pkg::stat_t stat,
    output hll_pkg::ctrl_t ctrl,
    output logic           busy
);
    import hll_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl = '0;
        busy = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                ctrl.clear_wr = 1'b1;
                ctrl.addr_inc = 1'b1;
                if (stat.addr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (mode)
                    begin
                        ctrl.sum_clr = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        ctrl.hash_load = 1'b1;
                        state_next = ST_HASH;
                    end
                end
            end
            ST_HASH:
            begin
                ctrl.hash_rd = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                ctrl.add_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                ctrl.scan_rd = 1'b1;
                ctrl.scan_acc = 1'b1;
                ctrl.addr_inc = 1'b1;
                if (stat.addr_last)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                ctrl.scan_acc = 1'b1;
                state_next = ST_DIV;
                ctrl.div_start = 1'b1;
            end
            ST_DIV:
            begin
                ctrl.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                ctrl.out_fire = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

// File: hdl/hll_datapath.sv
module hll_datapath #(
    parameter int BUCKETS = hll_pkg::DefBuckets
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [31:0]               value,
    input  hll_pkg::ctrl_t            ctrl,
    output hll_pkg::stat_t            stat,
    output logic                      done,
    output logic [hll_pkg::EstW-1:0]  estimate
);
    import hll_pkg::*;

    localparam int AddrW = $clog2(BUCKETS);
    localparam int IdxBits = clog2_floor(BUCKETS);
    localparam int LowBits = 32 - IdxBits;
    localparam int LenW = $clog2(LowBits + 1);
    localparam int SumW = FracBits + AddrW + 1;
    // K = round(7213 m^3 2^22 / (10 (1000 m + 1079))), with one extra bit for rounding.
    localparam logic [127:0] KNum =
        (128'(7213) * 128'(BUCKETS) * 128'(BUCKETS) * 128'(BUCKETS)) << (FracBits + 1);
    localparam logic [127:0] KDen = 128'(10) * (128'(1000) * 128'(BUCKETS) + 128'(1079));
    localparam logic [63:0] ScaleK = 64'(((KNum / KDen) + 128'd1) >> 1);
    localparam int QW = 64;
    localparam int CntW = $clog2(QW + 1);

    // Hash pipeline: the first multiply is registered in the load cycle, the
    // second finishes in the hash cycle, and the full hash is registered there.
    logic [31:0] m1_reg;
    logic [31:0] hash_reg;
    logic [31:0] h1, h2, hash;
    logic [31:0] m2;

    always_ff @(posedge clk)
    begin
        if (ctrl.hash_load)
        begin
            m1_reg <= ((value >> 16) ^ value) * HashMul;
        end
        if (ctrl.hash_rd)
        begin
            hash_reg <= hash;
        end
    end

    assign m2 = ((m1_reg >> 16) ^ m1_reg) * HashMul;
    assign hash = (m2 >> 16) ^ m2;
    assign h1 = hash_reg >> LowBits;
    assign h2 = hash_reg & ((32'd1 << LowBits) - 32'd1);

    // Bit length of the low part by a priority scan.
    logic [LenW-1:0] len;
    logic [RankW-1:0] rank;
    always_comb
    begin
        len = '0;
        for (int i = 0; i < LowBits; i++)
        begin
            if (h2[i])
            begin
                len = LenW'(i + 1);
            end
        end
        rank = RankW'(LowBits + 1 - int'(len));
    end

    // The bucket read is issued in the hash cycle and compared in the add cycle.
    logic [AddrW-1:0] addr_reg;
    logic [AddrW-1:0] idx;
    logic [AddrW-1:0] raddr, waddr;
    logic [RankW-1:0] rdata, wdata;
    logic             we;
    logic             idx_ok;
    logic [AddrW-1:0] pre_idx;

    assign pre_idx = AddrW'(hash >> LowBits);

    assign idx = AddrW'(h1);
    assign idx_ok = (h1 < 32'(BUCKETS));
    assign raddr = ctrl.hash_rd ? pre_idx : addr_reg;
    assign waddr = ctrl.add_wr ? idx : addr_reg;
    assign we = ctrl.clear_wr || (ctrl.add_wr && idx_ok && (rdata < rank));
    assign wdata = ctrl.clear_wr ? '0 : rank;

    hll_ram #(.WIDTH(RankW), .DEPTH(BUCKETS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
        end
        else if (ctrl.addr_inc)
        begin
            addr_reg <= (addr_reg == AddrW'(BUCKETS - 1)) ? '0 : addr_reg + 1'b1;
        end
    end
    assign stat.addr_last = (addr_reg == AddrW'(BUCKETS - 1));

    // Harmonic sum; a read issued in one scan cycle lands the next.
    logic [SumW-1:0] sum_reg;
    logic            acc_vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_vld_reg <= 1'b0;
        end
        else
        begin
            acc_vld_reg <= ctrl.scan_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.sum_clr)
        begin
            sum_reg <= '0;
        end
        else if (ctrl.scan_acc && acc_vld_reg && (rdata <= RankW'(FracBits)))
        begin
            sum_reg <= sum_reg + (SumW'(1) << (FracBits - int'(rdata)));
        end
    end

    // Restoring divider, one quotient bit a cycle.
    logic [QW-1:0]   q_reg;
    logic [SumW:0]   r_reg;
    logic [CntW-1:0] cnt_reg;
    logic [SumW:0]   r_sh;
    logic            zero_reg;

    assign r_sh = {r_reg[SumW-1:0], q_reg[QW-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctrl.div_start)
        begin
            cnt_reg <= CntW'(QW);
        end
        else if (ctrl.div_step && cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.div_start)
        begin
            q_reg <= ScaleK;
            r_reg <= '0;
            zero_reg <= 1'b0;
        end
        else if (ctrl.div_step && cnt_reg != '0)
        begin
            if (r_sh >= {1'b0, sum_reg})
            begin
                r_reg <= r_sh - {1'b0, sum_reg};
                q_reg <= {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                r_reg <= r_sh;
                q_reg <= {q_reg[QW-2:0], 1'b0};
            end
            zero_reg <= (sum_reg == '0);
        end
    end
    assign stat.div_done = (cnt_reg == CntW'(1));

    assign done = ctrl.out_fire;
    assign estimate = (zero_reg || (q_reg > 64'(EstMax))) ? EstMax : EstW'(q_reg);
endmodule

// File: hdl/hyperloglog_distinct_count.sv
// Add: the hash state and the read-modify-write state follow the transfer; busy
// is low again after them, so a new add is not accepted until both are through.
// Estimate: the walk reads one bucket a cycle across all BUCKETS entries, a last
// state drains the final read, then a 64-step divider runs before done is raised.
// After reset the rank RAM is cleared one entry a cycle across all entries with
// busy high. The receiver cannot stall.
module hyperloglog_distinct_count #(
    parameter int BUCKETS = hll_pkg::DefBuckets
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     mode,
    input  logic [31:0]              value,
    output logic                     done,
    output logic [hll_pkg::EstW-1:0] estimate
);
    import hll_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    hll_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    hll_datapath #(.BUCKETS(BUCKETS)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .value    (value),
        .ctrl     (ctrl),
        .stat     (stat),
        .done     (done),
        .estimate (estimate)
    );
endmodule

// File: hdl/hll_checker.sv
`include "assert_macros.svh"
module hll_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic mode,
    input logic done
);
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `ASSERT_IMPL(a_done_busy, clk, rst_n, done, busy)
    `ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)
    `ASSERT_NEXT(a_add_silent, clk, rst_n, start && !busy && !mode, !done)
endmodule

bind hyperloglog_distinct_count hll_checker u_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .mode  (mode),
    .done  (done)
);

// File: dv/hyperloglog_distinct_count_checker.sv
`timescale 1ns / 1ps

module hyperloglog_distinct_count_checker #(
    parameter int BUCKETS = hll_pkg::DefBuckets
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic                     mode,
    input  logic [31:0]              value,
    input  logic                     done,
    input  logic [hll_pkg::EstW-1:0] estimate,
    output int                       mismatches,
    output int                       pending,
    output int                       estimates_seen
);
    import hll_pkg::*;

    localparam int IdxBits = clog2_floor(BUCKETS);
    localparam int LowBits = 32 - IdxBits;

    logic [RankW-1:0]    rank_shadow [BUCKETS];
    logic [EstW-1:0]     expected_estimates [$];
    logic [63:0]         k_scale;

    function automatic logic [31:0] mix_value(input logic [31:0] v);
        logic [31:0] h;
        h = v;
        h = ((h >> 16) ^ h) * HashMul;
        h = ((h >> 16) ^ h) * HashMul;
        return (h >> 16) ^ h;
    endfunction

    task automatic add_to_sketch(input logic [31:0] v);
        logic [31:0] h;
        logic [31:0] idx;
        logic [31:0] rest;
        int len;
        int rank;
        h = mix_value(v);
        idx = h >> LowBits;
        rest = h & ((32'd1 << LowBits) - 32'd1);
        len = 0;
        while (len < 32 && (rest >> len) != 0) len++;
        rank = LowBits - len + 1;
        if (idx < BUCKETS && rank_shadow[idx] < rank)
            rank_shadow[idx] = RankW'(rank);
    endtask

    function automatic logic [EstW-1:0] predict_estimate();
        logic [63:0] total;
        logic [63:0] q;
        total = 0;
        for (int i = 0; i < BUCKETS; i++)
            if (rank_shadow[i] <= FracBits)
                total += 64'd1 << (FracBits - rank_shadow[i]);
        if (total == 0)
            return EstMax;
        q = k_scale / total;
        return (q > 64'(EstMax)) ? EstMax : q[EstW-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    initial
    begin
        // K is derived here independently of the datapath's ScaleK.
        logic [127:0] num;
        logic [127:0] den;
        num = 128'(7213) * BUCKETS * BUCKETS * BUCKETS;
        num = num << (FracBits + 1);
        den = 128'(10) * (128'(1000) * BUCKETS + 128'(1079));
        k_scale = 64'(((num / den) + 1) >> 1);
        for (int i = 0; i < BUCKETS; i++) rank_shadow[i] = '0;
        mismatches = 0;
        pending = 0;
        estimates_seen = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                estimates_seen++;
                if (expected_estimates.size() == 0)
                    report_mismatch($sformatf("unexpected estimate %0d", estimate));
                else
                begin
                    logic [EstW-1:0] exp_est;
                    exp_est = expected_estimates.pop_front();
                    if (estimate !== exp_est)
                        report_mismatch($sformatf("estimate %0d, expected %0d",
                            estimate, exp_est));
                end
            end
            // An accepted transfer: start high while busy is low.
            if (start && !busy)
            begin
                if (mode == 1'b0)
                    add_to_sketch(value);
                else
                    expected_estimates.push_back(predict_estimate());
            end
            pending = expected_estimates.size();
        end
    end
endmodule

// File: dv/hyperloglog_distinct_count_test.sv
`timescale 1ns / 1ps

module hyperloglog_distinct_count_test;
    import hll_pkg::*;

    localparam int BUCKETS = DefBuckets;
    localparam int RandItems = 1725;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic             mode;
    logic [31:0]      value;
    logic             done;
    logic [EstW-1:0]  estimate;
    int               mismatches;
    int               pending;
    int               estimates_seen;
    int               idle_pct;
    int               adds_sent;

    hyperloglog_distinct_count #(.BUCKETS(BUCKETS)) u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .value(value), .done(done), .estimate(estimate)
    );

    hyperloglog_distinct_count_checker #(.BUCKETS(BUCKETS)) u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .value(value), .done(done), .estimate(estimate),
        .mismatches(mismatches), .pending(pending), .estimates_seen(estimates_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Holds start high until the transfer is accepted, then idles at random.
    task automatic send_item(input logic m, input logic [31:0] v);
        start <= 1'b1;
        mode <= m;
        value <= v;
        @(posedge clk);
        while (busy) @(posedge clk);
        if (m == 1'b0) adds_sent++;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            mode <= 1'($urandom_range(1));
            value <= $urandom;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
    endtask

    initial
    begin
        logic [31:0] walk;
        start = 1'b0;
        mode = 1'b0;
        value = '0;
        rst_n = 1'b0;
        idle_pct = 29;
        adds_sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty sketch, then field extremes and single-bit walks.
        send_item(1'b1, 32'h0);
        send_item(1'b0, 32'h0);
        send_item(1'b0, 32'hFFFF_FFFF);
        walk = 32'h1;
        for (int i = 0; i < 16; i++)
        begin
            send_item(1'b0, walk);
            send_item(1'b0, ~walk);
            walk = walk << 2;
        end
        send_item(1'b1, 32'hFFFF_FFFF);

        for (int i = 0; i < RandItems; i++)
        begin
            if (i == RandItems / 3) idle_pct = 72;
            if (i == 2 * RandItems / 3) idle_pct = 0;
            // Estimates are slow: keep them to about one in twenty-five.
            if ($urandom_range(24) == 0)
                send_item(1'b1, $urandom);
            else if ($urandom_range(3) == 0)
                send_item(1'b0, $urandom_range(255));
            else
                send_item(1'b0, $urandom);
        end
        send_item(1'b1, $urandom);
        start <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (BUCKETS + 100) @(posedge clk);
        $display("Sent %0d adds; checked %0d estimates across three idle profiles.",
            adds_sent, estimates_seen);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
